// ----- rtl/core/onb_pkg.sv -----
package onb_pkg;

    localparam int unsigned DIR_W      = 16;
    localparam int unsigned ROOT_W     = 16;
    localparam int unsigned SQRT_LAT   = ROOT_W;
    localparam int unsigned PHI_NUM_W  = 31;
    localparam int unsigned PHI_W      = 16;
    localparam int unsigned PHI_LAT    = PHI_W;
    localparam int unsigned TAN_NUM_W  = 32;
    localparam int unsigned TAN_W      = 32;
    localparam int unsigned TAN_LAT    = TAN_W;
    // clamp, products, dot sum and sinAlpha scaling sit between the two divides
    localparam int unsigned M1_DLY     = TAN_LAT - PHI_LAT - 4;
    localparam int unsigned PIPE_DEPTH = 1 + SQRT_LAT + 1 + TAN_LAT + 4;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [15:0] SIN_THRESH = 16'd3;
    localparam logic [15:0] UNIT_Q15   = 16'd32768;
    localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
    localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
    localparam logic [15:0] OUT_MAX    = 16'hFFFF;
    localparam logic [15:0] REFL_RST   = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_A     = 3'd0,
        CFG_COEF_B     = 3'd1,
        CFG_REFL_RED   = 3'd2,
        CFG_REFL_GREEN = 3'd3,
        CFG_REFL_BLUE  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        sat;
    } t_result;

    typedef struct packed {
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] ix;
        logic signed [15:0] iy;
        logic [15:0]        co;
        logic [15:0]        ci;
        logic               zero;
        logic               i_gt_o;
    } t_side_a;

    typedef struct packed {
        logic [3:0]  neg;
        logic [3:0]  ovf;
        logic        thr;
        logic [15:0] sa;
    } t_side_b;

endpackage

// ----- rtl/core/onb_sqrt_pipe.sv -----
module onb_sqrt_pipe #(
    parameter int unsigned ROOT_W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output logic [ROOT_W-1:0]     o_root
);
    localparam int unsigned RAD_W = 2 * ROOT_W;
    localparam int unsigned REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];

    // one root bit per stage, two radicand bits brought down each time
    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  sub;
        logic [REM_W+1:0]  diff;
        logic              take;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end

        assign trial = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign sub   = {2'b00, root_in, 2'b01};
        assign take  = (trial >= sub);
        assign diff  = trial - sub;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? diff[REM_W-1:0] : trial[REM_W-1:0];
                r_root[k] <= {root_in[ROOT_W-2:0], take};
                r_rad[k]  <= rad_in << 2;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

// ----- rtl/core/onb_div_pipe.sv -----
module onb_div_pipe #(
    parameter int unsigned NUM_W = 31,
    parameter int unsigned DEN_W = 16,
    parameter int unsigned QUO_W = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);
    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_num [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    // restoring divide, one quotient bit per stage; upper bits above QUO_W
    // are taken as zero (caller checks for overflow)
    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] num_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_in = DEN_W'(i_num >> QUO_W);
            assign den_in = i_den;
            assign num_in = i_num[QUO_W-1:0];
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign num_in = r_num[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign trial = {rem_in, num_in[QUO_W-1]};
        assign take  = (trial >= {1'b0, den_in});
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_den[k] <= den_in;
                r_num[k] <= num_in << 1;
                r_quo[k] <= {quo_in[QUO_W-2:0], take};
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

// ----- rtl/core/onb_delay.sv -----
module onb_delay #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_sr [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_q = r_sr[DEPTH-1];

endmodule

// ----- rtl/core/oren_nayar_brdf_eval_unit.sv -----
// Oren-Nayar diffuse evaluation unit.
// Input channel: i_in_valid / o_in_ready carry one pair of local-frame
// directions (signed Q1.15). Output channel: o_out_valid / i_out_ready
// carry the RGB value in Q4.12 plus a saturation flag, one result per
// input, in order.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
// (A, B, red, green, blue) at once; unknown indices are dropped. Write
// only while no transfer is in flight.
// Throughput: one transfer per cycle while the skid entry is empty. The
// pipeline depth is set by the 16-stage square root followed by the
// 32-stage tanBeta divider.
// Reset (synchronous, active low) empties the pipeline and restores the
// register defaults (A = 1.0, B = 0, reflectances at full scale).
// When the receiver stalls, an output register plus one skid entry hold
// results; the pipeline freezes only once the skid entry is occupied, so
// nothing is dropped or repeated.
module oren_nayar_brdf_eval_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [onb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [15:0]                     i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [15:0]              i_out_dir_x,
    input  logic signed [15:0]              i_out_dir_y,
    input  logic signed [15:0]              i_out_dir_z,
    input  logic signed [15:0]              i_in_dir_x,
    input  logic signed [15:0]              i_in_dir_y,
    input  logic signed [15:0]              i_in_dir_z,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [15:0]                     o_value_red,
    output logic [15:0]                     o_value_green,
    output logic [15:0]                     o_value_blue,
    output logic                            o_saturated
);
    import onb_pkg::*;

    logic adv;

    // ---------------- configuration ----------------
    logic [15:0] r_coef_a;
    logic [15:0] r_coef_b;
    logic [15:0] r_refl [3];
    logic [22:0] r_rp   [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= UNIT_Q15;
            r_coef_b <= '0;
            r_refl[0] <= REFL_RST;
            r_refl[1] <= REFL_RST;
            r_refl[2] <= REFL_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_COEF_A:     r_coef_a  <= i_cfg_wdata;
                CFG_COEF_B:     r_coef_b  <= i_cfg_wdata;
                CFG_REFL_RED:   r_refl[0] <= i_cfg_wdata;
                CFG_REFL_GREEN: r_refl[1] <= i_cfg_wdata;
                CFG_REFL_BLUE:  r_refl[2] <= i_cfg_wdata;
                default:        ;
            endcase
        end
    end

    // R/pi in Q.24
    for (genvar c = 0; c < 3; c++) begin : g_rp
        logic [46:0] rp_full;
        assign rp_full = 47'(r_refl[c]) * 47'(INV_PI_Q32);
        always_ff @(posedge i_clk) begin
            r_rp[c] <= rp_full[46:24];
        end
    end

    // ---------------- valid chain ----------------
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  p_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end
    assign p_valid = r_vld[PIPE_DEPTH-1];

    // ---------------- stage A: 1 - z^2 ----------------
    logic [15:0] w_co;
    logic [15:0] w_ci;
    logic [31:0] r_a_rad_o;
    logic [31:0] r_a_rad_i;
    t_side_a     r_a_side;

    assign w_co = i_out_dir_z[15] ? 16'(-i_out_dir_z) : 16'(i_out_dir_z);
    assign w_ci = i_in_dir_z[15]  ? 16'(-i_in_dir_z)  : 16'(i_in_dir_z);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_rad_o <= ONE_Q30 - 32'(w_co) * 32'(w_co);
            r_a_rad_i <= ONE_Q30 - 32'(w_ci) * 32'(w_ci);
            r_a_side  <= '{ox: i_out_dir_x, oy: i_out_dir_y, ix: i_in_dir_x,
                           iy: i_in_dir_y, co: w_co, ci: w_ci,
                           zero: (w_co == '0) && (w_ci == '0),
                           i_gt_o: (w_ci > w_co)};
        end
    end

    // ---------------- sinTheta ----------------
    logic [15:0] w_so;
    logic [15:0] w_si;
    t_side_a     w_side17;

    onb_sqrt_pipe #(.ROOT_W(ROOT_W)) u_sqrt_o (
        .i_clk(i_clk), .i_en(adv), .i_rad(r_a_rad_o), .o_root(w_so)
    );
    onb_sqrt_pipe #(.ROOT_W(ROOT_W)) u_sqrt_i (
        .i_clk(i_clk), .i_en(adv), .i_rad(r_a_rad_i), .o_root(w_si)
    );
    onb_delay #(.WIDTH($bits(t_side_a)), .DEPTH(SQRT_LAT)) u_dly_a (
        .i_clk(i_clk), .i_en(adv), .i_d(r_a_side), .o_q(w_side17)
    );

    // ---------------- stage B: divider operands ----------------
    logic signed [15:0] w_dir   [4];
    logic [15:0]        w_b_abs [4];
    logic [15:0]        w_b_den [4];
    logic [3:0]         w_b_neg;
    logic [3:0]         w_b_ovf;
    logic [PHI_NUM_W-1:0] r_b_num [4];
    logic [15:0]        r_b_den [4];
    logic [TAN_NUM_W-1:0] r_b_tnum;
    logic [15:0]        r_b_tden;
    t_side_b            r_b_side;
    logic               r_b_zero;

    assign w_dir[0] = w_side17.ox;
    assign w_dir[1] = w_side17.oy;
    assign w_dir[2] = w_side17.ix;
    assign w_dir[3] = w_side17.iy;

    for (genvar k = 0; k < 4; k++) begin : g_b
        assign w_b_abs[k] = w_dir[k][15] ? 16'(-w_dir[k]) : 16'(w_dir[k]);
        assign w_b_neg[k] = w_dir[k][15];
        assign w_b_den[k] = (k < 2) ? w_so : w_si;
        // quotient would need more than 16 bits
        assign w_b_ovf[k] = ({1'b0, w_b_abs[k][15:1]} >= w_b_den[k]);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_b_num[k] <= {w_b_abs[k], 15'b0};
                r_b_den[k] <= w_b_den[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_tnum <= {(w_side17.i_gt_o ? w_si : w_so), 16'b0};
            r_b_tden <= w_side17.i_gt_o ? w_side17.ci : w_side17.co;
            r_b_side <= '{neg: w_b_neg, ovf: w_b_ovf,
                           thr: (w_so > SIN_THRESH) && (w_si > SIN_THRESH),
                           sa: (w_side17.i_gt_o ? w_so : w_si)};
            r_b_zero <= w_side17.zero;
        end
    end

    // ---------------- dividers ----------------
    logic [PHI_W-1:0] w_phi_q [4];
    logic [TAN_W-1:0] w_tan;
    t_side_b          w_side34;
    logic             w_zero50;

    for (genvar k = 0; k < 4; k++) begin : g_phi
        onb_div_pipe #(.NUM_W(PHI_NUM_W), .DEN_W(16), .QUO_W(PHI_W)) u_div_phi (
            .i_clk(i_clk), .i_en(adv), .i_num(r_b_num[k]), .i_den(r_b_den[k]),
            .o_quo(w_phi_q[k])
        );
    end

    onb_div_pipe #(.NUM_W(TAN_NUM_W), .DEN_W(16), .QUO_W(TAN_W)) u_div_tan (
        .i_clk(i_clk), .i_en(adv), .i_num(r_b_tnum), .i_den(r_b_tden), .o_quo(w_tan)
    );
    onb_delay #(.WIDTH($bits(t_side_b)), .DEPTH(PHI_LAT)) u_dly_b (
        .i_clk(i_clk), .i_en(adv), .i_d(r_b_side), .o_q(w_side34)
    );
    onb_delay #(.WIDTH(1), .DEPTH(TAN_LAT)) u_dly_z (
        .i_clk(i_clk), .i_en(adv), .i_d(r_b_zero), .o_q(w_zero50)
    );

    // ---------------- stage C: clamp and sign ----------------
    logic [15:0]        w_c_mag [4];
    logic signed [16:0] r_c_phi [4];
    logic               r_c_thr;
    logic [15:0]        r_c_sa;

    for (genvar k = 0; k < 4; k++) begin : g_c
        assign w_c_mag[k] = (w_side34.ovf[k] || (w_phi_q[k] > UNIT_Q15)) ?
                            UNIT_Q15 : w_phi_q[k];
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_c_phi[k] <= w_side34.neg[k] ? -$signed({1'b0, w_c_mag[k]})
                                              :  $signed({1'b0, w_c_mag[k]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_thr <= w_side34.thr;
            r_c_sa  <= w_side34.sa;
        end
    end

    // ---------------- stage D: products ----------------
    logic signed [33:0] r_d_p1;
    logic signed [33:0] r_d_p2;
    logic               r_d_thr;
    logic [15:0]        r_d_sa;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_p1  <= r_c_phi[0] * r_c_phi[2];
            r_d_p2  <= r_c_phi[1] * r_c_phi[3];
            r_d_thr <= r_c_thr;
            r_d_sa  <= r_c_sa;
        end
    end

    // ---------------- stage E: azimuth term ----------------
    logic signed [34:0] w_e_dot;
    logic [16:0]        r_e_term;
    logic [15:0]        r_e_sa;

    assign w_e_dot = r_d_p1 + r_d_p2;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_term <= (r_d_thr && !w_e_dot[34] && (w_e_dot != '0)) ?
                        w_e_dot[31:15] : '0;
            r_e_sa   <= r_d_sa;
        end
    end

    // ---------------- stage F: term * sinAlpha ----------------
    logic [32:0] w_f_prod;
    logic [17:0] r_f_m1;
    logic [17:0] w_m1_50;

    assign w_f_prod = 33'(r_e_term) * 33'(r_e_sa);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f_m1 <= w_f_prod[31:14];
        end
    end

    onb_delay #(.WIDTH(18), .DEPTH(M1_DLY)) u_dly_m (
        .i_clk(i_clk), .i_en(adv), .i_d(r_f_m1), .o_q(w_m1_50)
    );

    // ---------------- stages G..J ----------------
    logic [49:0] w_g_prod;
    logic [33:0] r_g_t;
    logic        r_g_zero;
    logic [49:0] w_h_prod;
    logic [34:0] r_h_bt;
    logic        r_h_zero;
    logic [35:0] r_i_s;
    logic        r_i_zero;
    logic [40:0] r_j_hi [3];
    logic [40:0] r_j_lo [3];
    logic        r_j_zero;

    assign w_g_prod = 50'(w_m1_50) * 50'(w_tan);
    assign w_h_prod = 50'(r_coef_b) * 50'(r_g_t);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_g_t    <= w_g_prod[49:16];
            r_g_zero <= w_zero50;
            r_h_bt   <= w_h_prod[49:15];
            r_h_zero <= r_g_zero;
            r_i_s    <= 36'({r_coef_a, 1'b0}) + 36'(r_h_bt);
            r_i_zero <= r_h_zero;
            r_j_zero <= r_i_zero;
        end
    end

    // wide product split into two partial products
    logic [58:0] w_k_sum [3];
    logic [30:0] w_k_v   [3];
    logic [2:0]  w_k_clip;
    logic [15:0] w_k_val [3];

    for (genvar c = 0; c < 3; c++) begin : g_ch
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_j_hi[c] <= 41'(r_rp[c]) * 41'(r_i_s[35:18]);
                r_j_lo[c] <= 41'(r_rp[c]) * 41'(r_i_s[17:0]);
            end
        end
        assign w_k_sum[c]  = {r_j_hi[c], 18'b0} + 59'(r_j_lo[c]);
        assign w_k_v[c]    = w_k_sum[c][58:28];
        assign w_k_clip[c] = |w_k_v[c][30:16];
        assign w_k_val[c]  = (r_j_zero || w_k_clip[c]) ? OUT_MAX : w_k_v[c][15:0];
    end

    t_result w_res;
    assign w_res = '{red: w_k_val[0], green: w_k_val[1], blue: w_k_val[2],
                     sat: r_j_zero || (|w_k_clip)};

    // ---------------- output register and skid ----------------
    logic    r_out_v;
    logic    n_out_v;
    logic    r_skid_v;
    logic    n_skid_v;
    t_result r_out;
    t_result r_skid;
    logic    push;

    assign adv  = !r_skid_v;
    assign push = p_valid && adv;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        if (!r_out_v || i_out_ready) begin
            n_out_v  = r_skid_v || push;
            n_skid_v = 1'b0;
        end else if (push) begin
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_out_ready) begin
            r_out <= r_skid_v ? r_skid : w_res;
        end
        if (adv) begin
            r_skid <= w_res;
        end
    end

    assign o_in_ready    = adv;
    assign o_out_valid   = r_out_v;
    assign o_value_red   = r_out.red;
    assign o_value_green = r_out.green;
    assign o_value_blue  = r_out.blue;
    assign o_saturated   = r_out.sat;

endmodule

// ----- rtl/core/onb_checker.sv -----
module onb_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [onb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [15:0]                     i_cfg_wdata,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  logic signed [15:0]              i_out_dir_x,
    input  logic signed [15:0]              i_out_dir_y,
    input  logic signed [15:0]              i_out_dir_z,
    input  logic signed [15:0]              i_in_dir_x,
    input  logic signed [15:0]              i_in_dir_y,
    input  logic signed [15:0]              i_in_dir_z,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [15:0]                     o_value_red,
    input  logic [15:0]                     o_value_green,
    input  logic [15:0]                     o_value_blue,
    input  logic                            o_saturated
);
    import onb_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_value_red) && $stable(o_value_green)
        && $stable(o_value_blue) && $stable(o_saturated))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> (o_value_red == OUT_MAX)
        || (o_value_green == OUT_MAX) || (o_value_blue == OUT_MAX))
        else $error("saturation flag without a clipped channel");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !$past(i_out_ready))
        else $error("input blocked without an output stall");

endmodule

bind oren_nayar_brdf_eval_unit onb_checker u_onb_checker (.*);

// ----- sim/tb_oren_nayar_brdf_eval_unit.sv -----
module tb_oren_nayar_brdf_eval_unit;
    import onb_pkg::*;

    typedef struct {
        logic signed [15:0] ox, oy, oz, ix, iy, iz;
    } t_dir_pair;

    // indices past the register list; writes to them are dropped
    localparam int CFG_IDX_SPARE_LO = 5;
    localparam int CFG_IDX_SPARE_HI = 7;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [15:0]        i_cfg_wdata = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [15:0] i_out_dir_x = '0, i_out_dir_y = '0, i_out_dir_z = '0;
    logic signed [15:0] i_in_dir_x = '0, i_in_dir_y = '0, i_in_dir_z = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [15:0]        o_value_red, o_value_green, o_value_blue;
    logic               o_saturated;

    t_dir_pair pending_dirs[$];
    t_result   expected_vals[$];
    int        n_errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    longint    coef_a_m, coef_b_m;
    longint    refl_m[3];

    oren_nayar_brdf_eval_unit u_dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic longint isqrt(longint v);
        longint r = 0;
        longint b = 64'd1 << 30;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint sine_of(longint z);
        longint s2 = (64'sd1 <<< 30) - z * z;
        return (s2 > 0) ? isqrt(s2) : 0;
    endfunction

    function automatic longint phi_of(longint c, longint s);
        longint q = (c * 32768) / s;
        if (q > 32768) q = 32768;
        if (q < -32768) q = -32768;
        return q;
    endfunction

    function automatic t_result brdf_predict(t_dir_pair d);
        longint ox = d.ox, oy = d.oy, oz = d.oz;
        longint ix = d.ix, iy = d.iy, iz = d.iz;
        longint so, si, co, ci, term, sa, tb, t, s16, rp, v, dd;
        t_result r;
        so = sine_of(oz);
        si = sine_of(iz);
        co = oz < 0 ? -oz : oz;
        ci = iz < 0 ? -iz : iz;
        r.sat = 1'b0;
        if (co == 0 && ci == 0) begin
            r.red = OUT_MAX; r.green = OUT_MAX; r.blue = OUT_MAX; r.sat = 1'b1;
            return r;
        end
        term = 0;
        if (si > 3 && so > 3) begin
            dd = phi_of(ix, si) * phi_of(ox, so) + phi_of(iy, si) * phi_of(oy, so);
            if (dd > 0) term = dd >> 15;
        end
        if (ci > co) begin
            sa = so;
            tb = (si << 16) / ci;
        end else begin
            sa = si;
            tb = (so << 16) / co;
        end
        t = (((term * sa) >> 14) * tb) >> 16;
        s16 = coef_a_m * 2 + ((coef_b_m * t) >> 15);
        for (int k = 0; k < 3; k++) begin
            rp = (refl_m[k] * 64'd1367130551) >> 24;
            v = (rp * s16) >> 28;
            if (v > 65535) begin
                v = 65535;
                r.sat = 1'b1;
            end
            if (k == 0) r.red = v[15:0];
            else if (k == 1) r.green = v[15:0];
            else r.blue = v[15:0];
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                expected_vals.push_back(brdf_predict('{i_out_dir_x, i_out_dir_y,
                    i_out_dir_z, i_in_dir_x, i_in_dir_y, i_in_dir_z}));
            end
            if (pending_dirs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_dir_pair d;
                d = pending_dirs.pop_front();
                i_out_dir_x <= d.ox; i_out_dir_y <= d.oy; i_out_dir_z <= d.oz;
                i_in_dir_x <= d.ix;  i_in_dir_y <= d.iy;  i_in_dir_z <= d.iz;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    // monitor
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_vals.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                t_result e;
                e = expected_vals.pop_front();
                if (o_value_red !== e.red) report_mismatch("red", o_value_red, e.red);
                if (o_value_green !== e.green)
                    report_mismatch("green", o_value_green, e.green);
                if (o_value_blue !== e.blue) report_mismatch("blue", o_value_blue, e.blue);
                if (o_saturated !== e.sat) report_mismatch("saturated", o_saturated, e.sat);
            end
        end
    end

    task automatic write_reg(int idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx[CFG_IDX_W-1:0];
        i_cfg_wdata <= val;
        case (idx)
            CFG_COEF_A:     coef_a_m = val;
            CFG_COEF_B:     coef_b_m = val;
            CFG_REFL_RED:   refl_m[0] = val;
            CFG_REFL_GREEN: refl_m[1] = val;
            CFG_REFL_BLUE:  refl_m[2] = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(int a, int b, int r, int g, int bl);
        write_reg(CFG_COEF_A, a);
        write_reg(CFG_COEF_B, b);
        write_reg(CFG_REFL_RED, r);
        write_reg(CFG_REFL_GREEN, g);
        write_reg(CFG_REFL_BLUE, bl);
    endtask

    task automatic push_dirs(int ox, int oy, int oz, int ix, int iy, int iz);
        t_dir_pair d;
        d.ox = ox; d.oy = oy; d.oz = oz; d.ix = ix; d.iy = iy; d.iz = iz;
        pending_dirs.push_back(d);
    endtask

    task automatic unit_dir(output int x, output int y, output int z);
        longint s, yy;
        z = $signed(16'($urandom));
        s = sine_of(z);
        x = int'($urandom_range(0, 2 * s)) - int'(s);
        yy = isqrt(s * s - longint'(x) * x);
        y = $urandom_range(1) ? int'(yy) : -int'(yy);
        if (y > 32767) y = 32767;
        if (x > 32767) x = 32767;
    endtask

    task automatic push_random(int n);
        int ox, oy, oz, ix, iy, iz;
        repeat (n) begin
            if ($urandom_range(99) < 75) begin
                unit_dir(ox, oy, oz);
                unit_dir(ix, iy, iz);
            end else begin
                ox = $signed(16'($urandom)); oy = $signed(16'($urandom));
                oz = $signed(16'($urandom)); ix = $signed(16'($urandom));
                iy = $signed(16'($urandom)); iz = $signed(16'($urandom));
            end
            push_dirs(ox, oy, oz, ix, iy, iz);
        end
    endtask

    // sampled away from the active edge so queue and valid have settled
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_dirs.size() != 0 || i_in_valid || expected_vals.size() != 0);
        repeat (70) @(posedge i_clk);
    endtask

    initial begin
        coef_a_m = 32768; coef_b_m = 0;
        refl_m[0] = 65535; refl_m[1] = 65535; refl_m[2] = 65535;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset defaults first
        push_dirs(0, 0, 0, 0, 0, 0);
        push_dirs(32767, 0, 0, -32768, 0, 0);
        push_dirs(0, 0, -32768, 0, 0, -32768);
        push_dirs(0, 0, 32767, 0, 0, 1);
        drain();
        set_regs(32768, 32768, 65535, 65535, 65535);
        push_dirs(23170, 0, 23170, 23170, 0, 23170);
        push_dirs(23170, 0, 23170, 16384, 16384, 16384);
        push_dirs(-23170, 0, 23170, 23170, 0, 23170);
        push_dirs(0, 32767, 100, 0, 32767, 3);
        push_dirs(32767, 32767, 1000, 32767, -32768, 2000);
        push_dirs(3, 3, 32767, 3, 3, 32766);
        push_dirs(0, 0, 0, 32767, 0, 1);
        push_dirs(1, 0, 32767, 0, 1, -32767);
        push_dirs(32767, 32767, 32767, 32767, 32767, 32767);
        push_dirs(-32768, -32768, -32768, -32768, -32768, 5);
        push_dirs(18000, -18000, 20000, 30000, 0, -10000);
        push_dirs(1, 1, 1, 1, 1, 1);
        drain();
        set_regs(0, 0, 0, 0, 0);
        push_dirs(23170, 0, 23170, 16384, 16384, 16384);
        push_dirs(0, 0, 0, 0, 0, 0);
        drain();
        write_reg(CFG_IDX_SPARE_LO, 16'h1234);
        write_reg(CFG_IDX_SPARE_HI, 16'hFFFF);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            case (ph)
                0: set_regs(32768, 32768, 65535, 65535, 65535);
                1: set_regs(0, 32768, 65535, 0, 30000);
                2: set_regs(32768, 0, 1, 65535, 0);
                default: set_regs($urandom_range(32768), $urandom_range(32768),
                                  $urandom_range(65535), $urandom_range(65535),
                                  $urandom_range(65535));
            endcase
            push_random(240);
            drain();
        end

        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
